// ===== rtl/priority_counting_semaphore_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Semaphore unit assertion macros
// Shared concurrent assertion wrappers for the semaphore unit RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_COUNTING_SEMAPHORE_UNIT_MACROS_SVH
`define PRIORITY_COUNTING_SEMAPHORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PCSU_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define PCSU_ASSERT(lbl, prop, msg) \
  `PCSU_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define PCSU_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define PCSU_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/pcsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Semaphore unit package
// Field widths, register indexes, mode codes and shared types.
// ----------------------------------------------------------------------------
package pcsu_pkg;

  localparam int ID_W        = 8;
  localparam int TASK_PRIO_W = 2;
  localparam int COUNT_W     = 8;
  localparam int WAITERS_W   = 4;
  localparam int CFG_IDX_W   = 2;

  localparam int DEF_WAIT_SLOTS      = 8;
  localparam int DEF_LOWEST_PRIORITY = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 2'd1;

  localparam logic MODE_TAKE = 1'b0;
  localparam logic MODE_GIVE = 1'b1;

  localparam logic [COUNT_W-1:0] RESET_MAX_COUNT     = 8'd1;
  localparam logic [COUNT_W-1:0] RESET_INITIAL_COUNT = 8'd1;

  // Command from the controller to the row of wait cells.
  typedef struct packed {
    logic append;
    logic remove;
  } chain_cmd_t;

endpackage

// ===== rtl/pcsu_cell.sv =====
// ----------------------------------------------------------------------------
// Wait cell
// Holds one waiter, matches it against the most urgent level and shifts left.
// ----------------------------------------------------------------------------
module pcsu_cell
  import pcsu_pkg::*;
#(
  parameter int LOWEST_PRIORITY = DEF_LOWEST_PRIORITY,
  localparam int PRIO_W = $clog2(LOWEST_PRIORITY + 2)
) (
  input  logic              clk,
  input  logic              rst,
  input  chain_cmd_t        cmd,
  input  logic              occ,
  input  logic              sel_append,
  input  logic [PRIO_W-1:0] min_prio,
  input  logic              found_in,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [PRIO_W-1:0] nb_prio,
  input  logic [ID_W-1:0]   new_id,
  input  logic [PRIO_W-1:0] new_prio,
  output logic [ID_W-1:0]   id,
  output logic [PRIO_W-1:0] prio,
  output logic              found_out,
  output logic              pick
);

  localparam logic [PRIO_W-1:0] EMPTY_PRIO = PRIO_W'(LOWEST_PRIORITY + 1);

  logic hit;

  assign hit       = occ && (prio == min_prio);
  assign pick      = hit && !found_in;
  // Every cell at or after the released one takes its right neighbour's entry.
  assign found_out = found_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio <= EMPTY_PRIO;
    end else if (cmd.remove && found_out) begin
      prio <= nb_prio;
    end else if (cmd.append && sel_append) begin
      prio <= new_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove && found_out) begin
      id <= nb_id;
    end else if (cmd.append && sel_append) begin
      id <= new_id;
    end
  end

endmodule

// ===== rtl/pcsu_chain.sv =====
// ----------------------------------------------------------------------------
// Wait cell row
// Row of wait cells in arrival order, with the most urgent level search.
// ----------------------------------------------------------------------------
module pcsu_chain
  import pcsu_pkg::*;
#(
  parameter int WAIT_SLOTS      = DEF_WAIT_SLOTS,
  parameter int LOWEST_PRIORITY = DEF_LOWEST_PRIORITY,
  localparam int PRIO_W = $clog2(LOWEST_PRIORITY + 2),
  localparam int TW     = $clog2(WAIT_SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  chain_cmd_t             cmd,
  input  logic [TW-1:0]          total,
  input  logic [ID_W-1:0]        new_id,
  input  logic [TASK_PRIO_W-1:0] new_prio,
  input  logic [PRIO_W-1:0]      min_sel,
  output logic [PRIO_W-1:0]      min_prio,
  output logic [ID_W-1:0]        woke_id
);

  `include "priority_counting_semaphore_unit_macros.svh"

  localparam int LEVELS = 2 ** PRIO_W;
  localparam logic [PRIO_W-1:0] EMPTY_PRIO = PRIO_W'(LOWEST_PRIORITY + 1);

  logic [WAIT_SLOTS-1:0][ID_W-1:0]   cell_id;
  logic [WAIT_SLOTS-1:0][PRIO_W-1:0] cell_prio;
  logic [WAIT_SLOTS-1:0][LEVELS-1:0] lvl_hit;
  logic [WAIT_SLOTS-1:0]             pick;
  logic [WAIT_SLOTS-1:0]             occ;
  logic [WAIT_SLOTS:0]               found;
  logic [LEVELS-1:0]                 present;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < WAIT_SLOTS; i++) begin : g_cell
    logic [ID_W-1:0]   nb_id;
    logic [PRIO_W-1:0] nb_prio;

    if (i == WAIT_SLOTS - 1) begin : g_last
      assign nb_id   = '0;
      assign nb_prio = EMPTY_PRIO;
    end else begin : g_inner
      assign nb_id   = cell_id[i+1];
      assign nb_prio = cell_prio[i+1];
    end

    assign occ[i]     = TW'(i) < total;
    assign lvl_hit[i] = occ[i] ? (LEVELS'(1) << cell_prio[i]) : '0;

    pcsu_cell #(
      .LOWEST_PRIORITY(LOWEST_PRIORITY)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .occ       (occ[i]),
      .sel_append(TW'(i) == total),
      .min_prio  (min_sel),
      .found_in  (found[i]),
      .nb_id     (nb_id),
      .nb_prio   (nb_prio),
      .new_id    (new_id),
      .new_prio  (PRIO_W'(new_prio)),
      .id        (cell_id[i]),
      .prio      (cell_prio[i]),
      .found_out (found[i+1]),
      .pick      (pick[i])
    );
  end

  always_comb begin
    present = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) begin
      present = present | lvl_hit[i];
    end
  end

  // The lowest level present among the waiters is the most urgent one.
  always_comb begin
    min_prio = '0;
    for (int v = LEVELS - 1; v >= 0; v--) begin
      if (present[v]) begin
        min_prio = PRIO_W'(v);
      end
    end
  end

  always_comb begin
    woke_id = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) begin
      woke_id = woke_id | (pick[i] ? cell_id[i] : '0);
    end
  end

  `PCSU_ASSERT(a_pick_single, $onehot0(pick), "more than one wait cell picked")
  `PCSU_ASSERT(a_remove_picks, cmd.remove |-> $onehot(pick), "release found no waiter")
  `PCSU_ASSERT(a_cmd_exclusive, !(cmd.append && cmd.remove), "append and release together")

endmodule

// ===== rtl/priority_counting_semaphore_unit.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore with priority wait list
// Top level: handshakes, count, configuration and the wait cell row.
// ----------------------------------------------------------------------------
// Each request word runs in an accept step and an execute step: when it is
// accepted the row of wait cells reports the most urgent priority level
// present, which is registered; in the execute step every cell compares
// itself with that level, the released waiter drives its id and the cells
// after it shift one place left, while the count and waiter total update and
// the result word is loaded. A new word is accepted only back in idle, so the
// block takes no new word before the last one is done. A result that waits
// in the output register holds the execute step until it is taken.
// Configuration writes are accepted only while no request word is being
// executed, and take precedence over a request word offered in the same
// cycle; a write of initial_count also loads the count. No clearing pass is
// needed after reset.
module priority_counting_semaphore_unit
  import pcsu_pkg::*;
#(
  parameter int WAIT_SLOTS      = DEF_WAIT_SLOTS,
  parameter int LOWEST_PRIORITY = DEF_LOWEST_PRIORITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [ID_W-1:0]        task_id,
  input  logic [TASK_PRIO_W-1:0] task_priority,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   granted,
  output logic                   blocked,
  output logic                   list_full,
  output logic                   woke_valid,
  output logic [ID_W-1:0]        woke_task,
  output logic [COUNT_W-1:0]     count_now,
  output logic [WAITERS_W-1:0]   waiters_now
);

  `include "priority_counting_semaphore_unit_macros.svh"

  localparam int PRIO_W = $clog2(LOWEST_PRIORITY + 2);
  localparam int TW     = $clog2(WAIT_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                   state;
  logic [COUNT_W-1:0]       max_count;
  logic [COUNT_W-1:0]       sem_count;
  logic [COUNT_W-1:0]       sem_count_next;
  logic [TW-1:0]            waiter_total;
  logic [TW-1:0]            waiter_total_next;
  logic                     op_mode;
  logic [ID_W-1:0]          op_id;
  logic [TASK_PRIO_W-1:0]   op_prio;
  logic [PRIO_W-1:0]        min_q;
  logic [PRIO_W-1:0]        min_prio;
  logic [ID_W-1:0]          woke_id;
  chain_cmd_t               cmd;
  chain_cmd_t               chain_cmd;
  logic                     fire;
  logic                     f_grant;
  logic                     f_block;
  logic                     f_full;
  logic                     f_woke;
  logic [TW+WAITERS_W-1:0]  total_wide;

  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign fire      = (state == ST_EXEC) && (!out_valid || out_ready);
  assign chain_cmd = fire ? cmd : '0;
  assign total_wide = (TW + WAITERS_W)'(waiter_total_next);

  always_comb begin
    sem_count_next    = sem_count;
    waiter_total_next = waiter_total;
    cmd               = '0;
    f_grant           = 1'b0;
    f_block           = 1'b0;
    f_full            = 1'b0;
    f_woke            = 1'b0;
    unique case (op_mode)
      MODE_TAKE: begin
        priority if (sem_count != '0) begin
          sem_count_next = sem_count - COUNT_W'(1);
          f_grant        = 1'b1;
        end else if (waiter_total == TW'(WAIT_SLOTS)) begin
          f_full = 1'b1;
        end else begin
          cmd.append        = 1'b1;
          waiter_total_next = waiter_total + TW'(1);
          f_block           = 1'b1;
        end
      end
      MODE_GIVE: begin
        priority if (waiter_total == '0) begin
          if (sem_count < max_count) begin
            sem_count_next = sem_count + COUNT_W'(1);
          end
        end else begin
          cmd.remove        = 1'b1;
          waiter_total_next = waiter_total - TW'(1);
          f_woke            = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  pcsu_chain #(
    .WAIT_SLOTS     (WAIT_SLOTS),
    .LOWEST_PRIORITY(LOWEST_PRIORITY)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (chain_cmd),
    .total   (waiter_total),
    .new_id  (op_id),
    .new_prio(op_prio),
    .min_sel (min_q),
    .min_prio(min_prio),
    .woke_id (woke_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      max_count     <= RESET_MAX_COUNT;
      sem_count     <= RESET_INITIAL_COUNT;
      waiter_total  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (fire) begin
        out_valid    <= 1'b1;
        sem_count    <= sem_count_next;
        waiter_total <= waiter_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Writes only arrive while the block is idle.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_COUNT) begin
          max_count <= cfg_data;
        end else if (cfg_index == REG_INITIAL_COUNT) begin
          sem_count <= cfg_data;
        end
      end
    end
  end

  // The cell row is stable while idle, so the search result is taken at accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode <= mode;
      op_id   <= task_id;
      op_prio <= task_priority;
      min_q   <= min_prio;
    end
    if (fire) begin
      granted     <= f_grant;
      blocked     <= f_block;
      list_full   <= f_full;
      woke_valid  <= f_woke;
      woke_task   <= f_woke ? woke_id : '0;
      count_now   <= sem_count_next;
      waiters_now <= total_wide[WAITERS_W-1:0];
    end
  end

  `PCSU_ASSERT(a_flags_exclusive, out_valid |-> $onehot0({granted, blocked, list_full, woke_valid}), "result flags overlap")
  `PCSU_ASSERT(a_total_bound, waiter_total <= TW'(WAIT_SLOTS), "waiter total beyond wait slots")
  `PCSU_ASSERT(a_woke_zero, (out_valid && !woke_valid) |-> (woke_task == '0), "woke id without release")
  `PCSU_ASSERT(a_accept_exec, (in_valid && in_ready) |=> (state == ST_EXEC && !in_ready), "accepted word not executed")

endmodule
